// ===== src/frp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and protocol constants for the Firmata receive parser.
// Depends on nothing; the other files in src but frp_stream_if use it by scoped names.
package frp_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [47:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  port_or_channel;
    logic [13:0] analog_value;
    logic [7:0]  data_low;
    logic [7:0]  data_high;
    logic [7:0]  pin_number;
    logic [47:0] stamp;
    logic        last;
  } out_item_t;

  localparam logic [7:0] CMD_DIGITAL   = 8'h90;
  localparam logic [7:0] CMD_ANALOG    = 8'hE0;
  localparam logic [7:0] CMD_VERSION   = 8'hF9;
  localparam logic [7:0] CMD_SYSEX     = 8'hF0;
  localparam logic [7:0] CMD_SYSEX_END = 8'hF7;
  localparam logic [7:0] SX_FIRMWARE   = 8'h79;
  localparam logic [7:0] SX_CAPABILITY = 8'h6C;
  localparam logic [7:0] SX_ANALOG_MAP = 8'h6A;
  localparam logic [7:0] PIN_END       = 8'h7F;
  localparam logic [7:0] CMD_HIGH_MASK = 8'hF0;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

  localparam logic [3:0] KIND_DIGITAL   = 4'd0;
  localparam logic [3:0] KIND_ANALOG    = 4'd1;
  localparam logic [3:0] KIND_VERSION   = 4'd2;
  localparam logic [3:0] KIND_CAP_ENTRY = 4'd3;
  localparam logic [3:0] KIND_CAP_DONE  = 4'd4;
  localparam logic [3:0] KIND_MAP_ENTRY = 4'd5;
  localparam logic [3:0] KIND_MAP_DONE  = 4'd6;
  localparam logic [3:0] KIND_BAD_CMD   = 4'd7;
  localparam logic [3:0] KIND_BAD_SYSEX = 4'd8;

  localparam int MAX_RESULTS = 16;
  localparam int PAIR_CNT_W  = 5;
  localparam int PAIR_IDX_W  = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SINGLE,
    S_READ,
    S_PAIR
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load_single;
    logic read_pair;
    logic load_pair;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_single;
    logic has_pairs;
    logic pair_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/frp_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one item of a given payload type.
// Used by the parser top level for its input and result channels.
interface frp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/frp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the Firmata receive parser.
// Depends on frp_pkg; drives commands to frp_datapath from its status.
module frp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  frp_pkg::dp_status_t status,
  output frp_pkg::ctrl_cmd_t  cmd
);

  frp_pkg::ctrl_state_t state;
  frp_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == frp_pkg::S_IDLE) && !rst;
    unique case (state)
      frp_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_next = frp_pkg::S_DISPATCH;
        end
      end
      frp_pkg::S_DISPATCH: begin
        if (status.has_single) begin
          state_next = frp_pkg::S_SINGLE;
        end else if (status.has_pairs) begin
          state_next = frp_pkg::S_READ;
        end else begin
          state_next = frp_pkg::S_IDLE;
        end
      end
      frp_pkg::S_SINGLE: begin
        if (status.out_free) begin
          cmd.load_single = 1'b1;
          state_next = frp_pkg::S_IDLE;
        end
      end
      frp_pkg::S_READ: begin
        cmd.read_pair = 1'b1;
        state_next = frp_pkg::S_PAIR;
      end
      frp_pkg::S_PAIR: begin
        if (status.out_free) begin
          cmd.load_pair = 1'b1;
          state_next = status.pair_last ? frp_pkg::S_IDLE : frp_pkg::S_READ;
        end
      end
      default: begin
        state_next = frp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/frp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the Firmata receive parser: framing registers, mode byte
// buffer, pair sequencing and the output register. Depends on frp_pkg.
module frp_datapath #(
  parameter int MODE_BUFFER_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  frp_pkg::in_item_t   in_data,
  input  frp_pkg::ctrl_cmd_t  cmd,
  output frp_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output frp_pkg::out_item_t  out_data
);

  localparam int AW = (MODE_BUFFER_BYTES > 1) ? $clog2(MODE_BUFFER_BYTES) : 1;
  localparam int CW = $clog2(MODE_BUFFER_BYTES + 1);

  logic [1:0]  byte_count, byte_count_next;
  logic [1:0]  bytes_wanted, bytes_wanted_next;
  logic [7:0]  command_code, command_code_next;
  logic [7:0]  sysex_code, sysex_code_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [7:0]  pin_counter, pin_counter_next;
  logic [CW-1:0] mode_byte_count, mode_byte_count_next;
  logic [47:0] start_time, start_time_next;

  frp_pkg::out_item_t single, single_next;
  logic has_single, has_single_next;
  logic has_pairs, has_pairs_next;
  logic [frp_pkg::PAIR_CNT_W-1:0] pair_total, pair_total_next;
  logic [frp_pkg::PAIR_IDX_W-1:0] pair_idx;
  logic [7:0] pair_pin, pair_pin_next;

  logic [7:0] mode_mem [MODE_BUFFER_BYTES];
  logic       mem_we;
  logic [7:0] rd_even, rd_odd;
  logic [AW-1:0] addr_even, addr_odd;

  logic [7:0]  b;
  logic [47:0] t;
  logic [7:0]  cmd_code;
  logic [CW-1:0] cnt_pairs;
  logic [frp_pkg::PAIR_CNT_W-1:0] pair_avail;

  assign b = in_data.rx_byte;
  assign t = in_data.arrival_time;
  assign cmd_code = (b < frp_pkg::CMD_SYSEX) ? (b & frp_pkg::CMD_HIGH_MASK) : b;
  assign cnt_pairs = mode_byte_count >> 1;
  assign pair_avail = (32'(cnt_pairs) > frp_pkg::MAX_RESULTS) ?
                      frp_pkg::PAIR_CNT_W'(frp_pkg::MAX_RESULTS) :
                      frp_pkg::PAIR_CNT_W'(cnt_pairs);

  always_comb begin
    byte_count_next = byte_count;
    bytes_wanted_next = bytes_wanted;
    command_code_next = command_code;
    sysex_code_next = sysex_code;
    first_byte_next = first_byte;
    second_byte_next = second_byte;
    pin_counter_next = pin_counter;
    mode_byte_count_next = mode_byte_count;
    start_time_next = start_time;
    single_next = '0;
    single_next.stamp = start_time;
    single_next.last = 1'b1;
    has_single_next = 1'b0;
    has_pairs_next = 1'b0;
    pair_total_next = pair_total;
    pair_pin_next = pair_pin;
    mem_we = 1'b0;

    if (byte_count == 2'd0) begin
      start_time_next = t;
      first_byte_next = b;
      command_code_next = cmd_code;
      byte_count_next = 2'd1;
      if (cmd_code == frp_pkg::CMD_DIGITAL || cmd_code == frp_pkg::CMD_ANALOG ||
          cmd_code == frp_pkg::CMD_VERSION) begin
        bytes_wanted_next = 2'd3;
      end else if (cmd_code == frp_pkg::CMD_SYSEX) begin
        bytes_wanted_next = 2'd2;
      end else begin
        has_single_next = 1'b1;
        single_next.kind = frp_pkg::KIND_BAD_CMD;
        single_next.data_low = cmd_code;
        single_next.stamp = t;
        byte_count_next = 2'd0;
        bytes_wanted_next = 2'd1;
      end
    end else if (command_code == frp_pkg::CMD_SYSEX) begin
      if (bytes_wanted == 2'd2) begin
        sysex_code_next = b;
        if (b == frp_pkg::SX_CAPABILITY) begin
          pin_counter_next = '0;
          mode_byte_count_next = '0;
        end else if (b == frp_pkg::SX_ANALOG_MAP) begin
          pin_counter_next = '0;
        end else if (b != frp_pkg::SX_FIRMWARE) begin
          has_single_next = 1'b1;
          single_next.kind = frp_pkg::KIND_BAD_SYSEX;
          single_next.data_low = b;
        end
        byte_count_next = 2'd2;
        bytes_wanted_next = 2'd3;
      end else if (b == frp_pkg::CMD_SYSEX_END) begin
        if (sysex_code == frp_pkg::SX_CAPABILITY) begin
          has_single_next = 1'b1;
          single_next.kind = frp_pkg::KIND_CAP_DONE;
        end else if (sysex_code == frp_pkg::SX_ANALOG_MAP) begin
          has_single_next = 1'b1;
          single_next.kind = frp_pkg::KIND_MAP_DONE;
        end
        byte_count_next = 2'd0;
        bytes_wanted_next = 2'd1;
      end else begin
        if (sysex_code == frp_pkg::SX_CAPABILITY) begin
          if (b != frp_pkg::PIN_END) begin
            if (32'(mode_byte_count) < MODE_BUFFER_BYTES) begin
              mem_we = 1'b1;
              mode_byte_count_next = CW'(mode_byte_count + 1'b1);
            end
          end else begin
            has_pairs_next = (pair_avail != '0);
            pair_total_next = pair_avail;
            pair_pin_next = pin_counter;
            mode_byte_count_next = '0;
            pin_counter_next = pin_counter + 8'd1;
          end
        end else if (sysex_code == frp_pkg::SX_ANALOG_MAP) begin
          if (b != frp_pkg::PIN_END) begin
            has_single_next = 1'b1;
            single_next.kind = frp_pkg::KIND_MAP_ENTRY;
            single_next.data_low = b;
            single_next.pin_number = pin_counter;
          end
          pin_counter_next = pin_counter + 8'd1;
        end
        byte_count_next = 2'd2;
      end
    end else if (byte_count == 2'd1) begin
      second_byte_next = b;
      byte_count_next = 2'd2;
    end else begin
      single_next.port_or_channel = 4'(first_byte & frp_pkg::NIBBLE_MASK);
      if (command_code == frp_pkg::CMD_DIGITAL) begin
        has_single_next = 1'b1;
        single_next.kind = frp_pkg::KIND_DIGITAL;
        single_next.data_low = second_byte;
        single_next.data_high = b;
      end else if (command_code == frp_pkg::CMD_ANALOG) begin
        has_single_next = 1'b1;
        single_next.kind = frp_pkg::KIND_ANALOG;
        single_next.analog_value = {b[6:0], second_byte[6:0]};
      end else if (command_code == frp_pkg::CMD_VERSION) begin
        has_single_next = 1'b1;
        single_next.kind = frp_pkg::KIND_VERSION;
        single_next.port_or_channel = '0;
        single_next.data_low = second_byte;
        single_next.data_high = b;
      end
      byte_count_next = 2'd0;
      bytes_wanted_next = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      bytes_wanted <= 2'd1;
      command_code <= '0;
      sysex_code <= '0;
      first_byte <= '0;
      second_byte <= '0;
      pin_counter <= '0;
      mode_byte_count <= '0;
      start_time <= '0;
      has_single <= 1'b0;
      has_pairs <= 1'b0;
      pair_total <= '0;
      pair_idx <= '0;
    end else if (cmd.accept) begin
      byte_count <= byte_count_next;
      bytes_wanted <= bytes_wanted_next;
      command_code <= command_code_next;
      sysex_code <= sysex_code_next;
      first_byte <= first_byte_next;
      second_byte <= second_byte_next;
      pin_counter <= pin_counter_next;
      mode_byte_count <= mode_byte_count_next;
      start_time <= start_time_next;
      has_single <= has_single_next;
      has_pairs <= has_pairs_next;
      pair_total <= pair_total_next;
      pair_idx <= '0;
    end else if (cmd.load_pair) begin
      pair_idx <= pair_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      single <= single_next;
      pair_pin <= pair_pin_next;
    end
  end

  // Capability mode buffer: one write port, two registered read ports.
  assign addr_even = AW'({pair_idx, 1'b0});
  assign addr_odd  = AW'({pair_idx, 1'b1});

  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) begin
      mode_mem[mode_byte_count[AW-1:0]] <= b;
    end
    if (cmd.read_pair) begin
      rd_even <= mode_mem[addr_even];
      rd_odd <= mode_mem[addr_odd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_pair) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_data <= single;
    end else if (cmd.load_pair) begin
      out_data.kind <= frp_pkg::KIND_CAP_ENTRY;
      out_data.port_or_channel <= '0;
      out_data.analog_value <= '0;
      out_data.data_low <= rd_even;
      out_data.data_high <= rd_odd;
      out_data.pin_number <= pair_pin;
      out_data.stamp <= start_time;
      out_data.last <= status.pair_last;
    end
  end

  assign status.has_single = has_single;
  assign status.has_pairs = has_pairs;
  assign status.pair_last = (frp_pkg::PAIR_CNT_W'(pair_idx) + frp_pkg::PAIR_CNT_W'(1))
                            == pair_total;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== src/firmata_receive_parser_core.sv =====
`timescale 1ns / 1ps
// Firmata receive parser: frames channel messages and SysEx replies per byte.
// Each accepted byte is dispatched, then a single result, if any, goes to the
// output register. A capability pin end emits up to 16 entries, each by a mode
// buffer read, then an output register load. No new byte is taken until done.
// Synchronous reset clears framing state; the mode buffer is not cleared.
module firmata_receive_parser_core #(
  parameter int MODE_BUFFER_BYTES = 32
) (
  input logic         clk,
  input logic         rst,
  frp_stream_if.sink   in_ch,
  frp_stream_if.source out_ch
);

  frp_pkg::ctrl_cmd_t  cmd;
  frp_pkg::dp_status_t status;
  frp_pkg::out_item_t  out_data;
  logic                out_valid;
  logic                in_ready;

  frp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  frp_datapath #(
    .MODE_BUFFER_BYTES (MODE_BUFFER_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted on two consecutive cycles");

  a_kind_in_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.data.kind <= frp_pkg::KIND_BAD_SYSEX))
    else $error("result kind out of range");

  a_pin_only_on_entries: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.kind != frp_pkg::KIND_CAP_ENTRY &&
     out_ch.data.kind != frp_pkg::KIND_MAP_ENTRY) |-> (out_ch.data.pin_number == 8'd0))
    else $error("pin number set on a result that is not an entry");

  a_analog_only_on_analog: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.kind != frp_pkg::KIND_ANALOG) |->
    (out_ch.data.analog_value == 14'd0))
    else $error("analog value set on a non-analog result");

endmodule
